// ----- rtl/core/glba_pkg.sv -----
`default_nettype none
package glba_pkg;

  typedef enum logic [2:0] {
    MODE_GRAY8 = 3'd0,
    MODE_MONO  = 3'd1,
    MODE_GRAY2 = 3'd2,
    MODE_GRAY4 = 3'd3,
    MODE_BGRA  = 3'd4
  } pix_mode_t;

  // configuration register indexes
  localparam logic CFG_PIXEL_MODE      = 1'b0;
  localparam logic CFG_ALPHA_AS_COLOUR = 1'b1;

  localparam int unsigned CFG_DATA_W = 3;

  // pixels per item for each mode
  localparam logic [3:0] CAP_GRAY8 = 4'd1;
  localparam logic [3:0] CAP_MONO  = 4'd8;
  localparam logic [3:0] CAP_GRAY2 = 4'd4;
  localparam logic [3:0] CAP_GRAY4 = 4'd2;
  localparam logic [3:0] CAP_BGRA  = 4'd1;

  // x / 3 == (x * 683) >> 11 for every x below 2048
  localparam logic [9:0] RECIP3       = 10'd683;
  localparam int unsigned RECIP3_SHIFT = 11;

  localparam logic [7:0] BYTE_FULL = 8'hFF;

  // one classified item waiting for the back end
  typedef struct packed {
    pix_mode_t  mode;
    logic       aac;        // alpha copied into colour
    logic [7:0] data;       // source byte, or BGRA colour quotient
    logic [7:0] bgra_alpha;
    logic [3:0] count;      // pixels to emit, 1..8
    logic       row_end;
  } glba_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } glba_qstat_t;

endpackage
`default_nettype wire

// ----- rtl/core/glyph_bitmap_to_luma_alpha.sv -----
`default_nettype none
// An accepted item is written into the queue, then loaded into the unpacker's item register,
// and each pixel is registered onto the output with its strobe. Throughput: one pixel per
// cycle while items are queued; an item carries 1 to 8 pixels over the single output port.
// busy rises while the two-entry queue between classifier and unpacker is full.
// Reset (rst_n low, synchronous) selects gray8, clears alpha-as-colour, empties the
// queue and drops the strobe; the receiver cannot stall, so no pixel waits.
module glyph_bitmap_to_luma_alpha
  import glba_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [31:0]           in_source_bytes,
  input  wire logic [3:0]            in_valid_pixels,
  input  wire logic                  in_row_end,
  output logic                       out_strobe,
  output logic [7:0]                 out_colour_byte,
  output logic [7:0]                 out_alpha_byte,
  output logic                       out_item_last,
  output logic                       out_row_last
);

  glba_entry_t front_entry;
  glba_entry_t head;
  glba_qstat_t stat;
  logic        push;
  logic        pop;

  // hold off new items only while the queue has no free slot
  assign busy = stat.full;

  // front: hold the registers, clip the pixel count, precompute the BGRA colour,
  // drop items that would produce nothing
  glba_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start           (start),
    .q_full          (stat.full),
    .in_source_bytes (in_source_bytes),
    .in_valid_pixels (in_valid_pixels),
    .in_row_end      (in_row_end),
    .entry           (front_entry),
    .push            (push)
  );

  // queue: decouple the accepting side from the pixel stream
  glba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  // back: unpack fields most significant first, one pixel per cycle while items are queued,
  // and fetch the next item on the cycle of the last pixel so the stream stays gapless
  glba_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .stat            (stat),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_colour_byte (out_colour_byte),
    .out_alpha_byte  (out_alpha_byte),
    .out_item_last   (out_item_last),
    .out_row_last    (out_row_last)
  );

endmodule
`default_nettype wire

// ----- rtl/core/glba_front.sv -----
`default_nettype none
module glba_front
  import glba_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  start,
  input  wire logic                  q_full,
  input  wire logic [31:0]           in_source_bytes,
  input  wire logic [3:0]            in_valid_pixels,
  input  wire logic                  in_row_end,
  output glba_entry_t                entry,
  output logic                       push
);

  logic [2:0]  src_fmt_r;
  logic        aac_r;
  logic [3:0]  cap;
  logic        known;
  logic [9:0]  bgr_sum;
  logic [19:0] bgr_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= 3'd0;
      aac_r     <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PIXEL_MODE) src_fmt_r <= cfg_data;
      else                             aac_r     <= cfg_data[0];
    end
  end

  always_comb begin
    known = 1'b1;
    unique case (pix_mode_t'(src_fmt_r))
      MODE_GRAY8: cap = CAP_GRAY8;
      MODE_MONO:  cap = CAP_MONO;
      MODE_GRAY2: cap = CAP_GRAY2;
      MODE_GRAY4: cap = CAP_GRAY4;
      MODE_BGRA:  cap = CAP_BGRA;
      default: begin
        cap   = 4'd0;
        known = 1'b0;
      end
    endcase
  end

  // divide B+G+R by three through the reciprocal
  assign bgr_sum  = {2'b00, in_source_bytes[7:0]} + {2'b00, in_source_bytes[15:8]}
                  + {2'b00, in_source_bytes[23:16]};
  assign bgr_prod = {10'd0, bgr_sum} * {10'd0, RECIP3};

  always_comb begin
    entry.mode       = pix_mode_t'(src_fmt_r);
    entry.aac        = aac_r;
    entry.data       = (pix_mode_t'(src_fmt_r) == MODE_BGRA)
                     ? bgr_prod[RECIP3_SHIFT +: 8] : in_source_bytes[7:0];
    entry.bgra_alpha = in_source_bytes[31:24];
    entry.count      = (in_valid_pixels > cap) ? cap : in_valid_pixels;
    entry.row_end    = in_row_end;
  end

  // drop items of unknown mode or without pixels
  assign push = start && !q_full && known && (entry.count != 4'd0);

endmodule
`default_nettype wire

// ----- rtl/core/glba_queue.sv -----
`default_nettype none
module glba_queue
  import glba_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  glba_entry_t push_entry,
  input  wire logic  pop,
  output glba_entry_t head,
  output glba_qstat_t stat
);

  glba_entry_t mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty)) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- rtl/core/glba_back.sv -----
`default_nettype none
module glba_back
  import glba_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  glba_entry_t head,
  input  glba_qstat_t stat,
  output logic       pop,
  output logic       out_strobe,
  output logic [7:0] out_colour_byte,
  output logic [7:0] out_alpha_byte,
  output logic       out_item_last,
  output logic       out_row_last
);

  glba_entry_t cur_r;
  logic        active_r;
  logic [2:0]  k_r;
  logic        last;
  logic [7:0]  colour;
  logic [7:0]  alpha;
  logic [1:0]  g2;
  logic [3:0]  g4;

  assign last = ({1'b0, k_r} + 4'd1) == cur_r.count;
  assign pop  = !stat.empty && (!active_r || last);

  assign g2 = cur_r.data[{~k_r[1:0], 1'b1} -: 2];
  assign g4 = cur_r.data[{~k_r[0], 2'b11} -: 4];

  always_comb begin
    unique case (cur_r.mode)
      MODE_GRAY8: alpha = cur_r.data;
      MODE_MONO:  alpha = {8{cur_r.data[~k_r]}};
      MODE_GRAY2: alpha = {4{g2}};   // g * 85
      MODE_GRAY4: alpha = {2{g4}};   // g * 17
      default:    alpha = cur_r.bgra_alpha;
    endcase
    unique case (cur_r.mode)
      MODE_MONO: colour = alpha;
      MODE_BGRA: colour = cur_r.data;
      default:   colour = cur_r.aac ? alpha : BYTE_FULL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= active_r;
      if (pop) begin
        cur_r    <= head;
        k_r      <= 3'd0;
        active_r <= 1'b1;
      end else if (active_r && last) begin
        active_r <= 1'b0;
      end else if (active_r) begin
        k_r <= k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active_r) begin
      out_colour_byte <= colour;
      out_alpha_byte  <= alpha;
      out_item_last   <= last;
      out_row_last    <= last && cur_r.row_end;
    end
  end

  a_row_implies_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_row_last |-> out_item_last)
    else $error("row_last without item_last");
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ({1'b0, k_r} < cur_r.count))
    else $error("pixel index beyond item count");

endmodule
`default_nettype wire
